FILE: rtl/csc_pkg.sv
// Shared types, constants and arithmetic helpers for the coordinate system converter.
// Used by the CORDIC cell and the top level; depends on nothing else.
`timescale 1ns / 1ps

package csc_pkg;

   // Number of CORDIC iterations in each row of cells.
   localparam int CORDIC_STAGES = 24;
   localparam int IDX_W = 5;

   // Datapath widths.
   localparam int DW = 52;        // CORDIC x and y
   localparam int ZW = 34;        // CORDIC angle accumulator
   localparam int CW = 30;        // sine and cosine in Q28
   localparam int PW = 72;        // full products
   localparam int QW = PW - 28;   // products after removing 28 fraction bits
   localparam int RW = 36;        // rounded length products carried down the pipe
   localparam int MW = 52;        // guarded magnitudes
   localparam int HW = 56;        // gain compensation partial products
   localparam int GUARD = 16;     // guard bits on lengths in vectoring mode

   localparam logic signed [ZW-1:0] PI_Q      = ZW'(843314857);
   localparam logic signed [ZW-1:0] TWO_PI_Q  = ZW'(1686629713);
   localparam logic signed [ZW-1:0] HALF_PI_Q = ZW'(421657428);
   localparam logic [27:0]          INV_GAIN  = 28'd163008219;

   typedef enum logic [2:0] {
      OP_RECT_CYL = 3'd0,
      OP_RECT_SPH = 3'd1,
      OP_CYL_RECT = 3'd2,
      OP_CYL_SPH  = 3'd3,
      OP_SPH_CYL  = 3'd4,
      OP_SPH_RECT = 3'd5
   } op_type;

   // State of one CORDIC iteration.
   typedef struct packed {
      logic                   vec;    // vectoring when set, rotation otherwise
      logic                   neg;    // rotation result must be negated
      logic                   zero;   // vectoring input was the zero vector
      logic signed [DW-1:0]   x;
      logic signed [DW-1:0]   y;
      logic signed [ZW-1:0]   z;
   } cordic_type;

   // Item fields that travel alongside the CORDIC state.
   typedef struct packed {
      logic                   valid;
      logic [2:0]             op;
      logic signed [31:0]     a;      // first input field
      logic signed [31:0]     rb;     // reduced second input field
      logic signed [31:0]     c;      // third input field
      logic signed [31:0]     ang;    // angle from the first row
      logic signed [RW-1:0]   mc;     // a times cosine from the first row
      logic signed [RW-1:0]   ms;     // a times sine from the first row
      logic [MW-1:0]          mag;    // guarded magnitude from the first row
   } side_type;

   typedef struct packed {
      cordic_type cr;
      side_type   sd;
   } cell_type;

   typedef struct packed {
      logic               ovf;
      logic signed [31:0] val;
   } sat_type;

   // Arctangent of 2^-i in Q28.
   function automatic logic signed [ZW-1:0] atan_q28(input logic [IDX_W-1:0] idx);
      logic signed [ZW-1:0] r;
      case (idx)
         5'd0:    r = ZW'(210828714);
         5'd1:    r = ZW'(124459479);
         5'd2:    r = ZW'(65760959);
         5'd3:    r = ZW'(33381290);
         5'd4:    r = ZW'(16755422);
         5'd5:    r = ZW'(8385879);
         5'd6:    r = ZW'(4193963);
         5'd7:    r = ZW'(2097109);
         5'd8:    r = ZW'(1048571);
         5'd9:    r = ZW'(524287);
         5'd10:   r = ZW'(262144);
         5'd11:   r = ZW'(131072);
         5'd12:   r = ZW'(65536);
         5'd13:   r = ZW'(32768);
         5'd14:   r = ZW'(16384);
         5'd15:   r = ZW'(8192);
         5'd16:   r = ZW'(4096);
         5'd17:   r = ZW'(2048);
         5'd18:   r = ZW'(1024);
         5'd19:   r = ZW'(512);
         5'd20:   r = ZW'(256);
         5'd21:   r = ZW'(128);
         5'd22:   r = ZW'(64);
         5'd23:   r = ZW'(32);
         5'd24:   r = ZW'(16);
         5'd25:   r = ZW'(8);
         5'd26:   r = ZW'(4);
         5'd27:   r = ZW'(2);
         5'd28:   r = ZW'(1);
         default: r = '0;
      endcase
      return r;
   endfunction

   // Brings any 32-bit angle into [-pi, pi]; one correction always suffices.
   function automatic logic signed [ZW-1:0] reduce_angle(input logic signed [31:0] v);
      logic signed [ZW-1:0] w;
      w = ZW'(v);
      if (w > PI_Q) begin
         w = w - TWO_PI_Q;
      end else if (w < -PI_Q) begin
         w = w + TWO_PI_Q;
      end
      return w;
   endfunction

   // Length with guard bits appended.
   function automatic logic signed [DW-1:0] guard_len(input logic signed [31:0] v);
      return DW'($signed({v, {GUARD{1'b0}}}));
   endfunction

   // Vectoring setup: a vector in the left half plane is turned by pi first.
   function automatic cordic_type vec_init(input logic signed [DW-1:0] x,
                                           input logic signed [DW-1:0] y);
      cordic_type r;
      r.vec  = 1'b1;
      r.neg  = 1'b0;
      r.zero = (x == '0) && (y == '0);
      if (x[DW-1]) begin
         r.x = -x;
         r.y = -y;
         r.z = y[DW-1] ? -PI_Q : PI_Q;
      end else begin
         r.x = x;
         r.y = y;
         r.z = '0;
      end
      return r;
   endfunction

   // Rotation setup: angles beyond pi/2 are folded and the result negated.
   function automatic cordic_type rot_init(input logic signed [ZW-1:0] ang);
      cordic_type r;
      r.vec  = 1'b0;
      r.zero = 1'b0;
      r.x    = DW'(INV_GAIN);
      r.y    = '0;
      if (ang > HALF_PI_Q) begin
         r.z   = ang - PI_Q;
         r.neg = 1'b1;
      end else if (ang < -HALF_PI_Q) begin
         r.z   = ang + PI_Q;
         r.neg = 1'b1;
      end else begin
         r.z   = ang;
         r.neg = 1'b0;
      end
      return r;
   endfunction

   // Drops 28 fraction bits, rounding half away from zero.
   function automatic logic signed [QW-1:0] round_q28(input logic signed [PW-1:0] p);
      logic [PW-1:0] m;
      logic [PW-1:0] q;
      m = p[PW-1] ? -p : p;
      q = (m + (PW'(1) << 27)) >> 28;
      return p[PW-1] ? -$signed(q[QW-1:0]) : $signed(q[QW-1:0]);
   endfunction

   // Clamps to the signed 32-bit range and flags a clamp.
   function automatic sat_type sat32(input logic signed [QW-1:0] v);
      sat_type r;
      if ((v[QW-1:31] == '0) || (v[QW-1:31] == '1)) begin
         r.ovf = 1'b0;
         r.val = v[31:0];
      end else begin
         r.ovf = 1'b1;
         r.val = v[QW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      return r;
   endfunction

   // Removes the guard bits from a magnitude, rounding half up.
   function automatic logic signed [QW-1:0] unguard(input logic [MW-1:0] m);
      logic [MW-1:0] t;
      t = (m + MW'(1 << (GUARD - 1))) >> GUARD;
      return QW'(t);
   endfunction

   // Clamps a CORDIC angle into [-pi, pi].
   function automatic logic signed [31:0] clamp_angle(input logic signed [ZW-1:0] z);
      logic signed [ZW-1:0] r;
      if (z > PI_Q) begin
         r = PI_Q;
      end else if (z < -PI_Q) begin
         r = -PI_Q;
      end else begin
         r = z;
      end
      return r[31:0];
   endfunction

   // Nonnegative vectoring magnitude ahead of gain compensation.
   function automatic logic [DW-2:0] mag_operand(input cordic_type c);
      return (c.zero || c.x[DW-1]) ? '0 : c.x[DW-2:0];
   endfunction

   // Joins the two gain compensation partial products with rounding.
   function automatic logic [MW-1:0] comp_sum(input logic [HW-1:0] hi, input logic [HW-1:0] lo);
      logic [HW-1:0] s;
      s = hi + ((lo + HW'(1 << 27)) >> 28);
      return s[MW-1:0];
   endfunction

endpackage

FILE: rtl/csc_cordic_cell.sv
// One CORDIC iteration cell: a registered micro-rotation in vectoring or rotation mode.
// Depends on csc_pkg for the cell state type and the arctangent table.
`timescale 1ns / 1ps

module csc_cordic_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic [csc_pkg::IDX_W-1:0]  stage_idx,
   input  csc_pkg::cell_type          prev_cell,
   output csc_pkg::cell_type          next_cell
);
   import csc_pkg::*;

   logic                 valid_ff;
   cell_type             data_ff;
   cell_type             data_in;
   logic                 sigma;
   logic signed [DW-1:0] dx;
   logic signed [DW-1:0] dy;
   logic signed [ZW-1:0] at;

   // Vectoring drives y toward zero, rotation drives z toward zero.
   always_comb begin
      dx    = prev_cell.cr.y >>> stage_idx;
      dy    = prev_cell.cr.x >>> stage_idx;
      at    = atan_q28(stage_idx);
      sigma = prev_cell.cr.vec ? ~prev_cell.cr.y[DW-1] : prev_cell.cr.z[ZW-1];
      data_in = prev_cell;
      if (sigma) begin
         data_in.cr.x = prev_cell.cr.x + dx;
         data_in.cr.y = prev_cell.cr.y - dy;
         data_in.cr.z = prev_cell.cr.z + at;
      end else begin
         data_in.cr.x = prev_cell.cr.x - dx;
         data_in.cr.y = prev_cell.cr.y + dy;
         data_in.cr.z = prev_cell.cr.z - at;
      end
   end

   // Valid bit of the item held in this cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= prev_cell.sd.valid;
      end
   end

   // Payload of the item held in this cell.
   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= data_in;
      end
   end

   always_comb begin
      next_cell          = data_ff;
      next_cell.sd.valid = valid_ff;
   end

endmodule

FILE: rtl/coordinate_system_converter_core.sv
// Top level of the coordinate system converter: two rows of CORDIC cells with
// scaling stages between them. Depends on csc_pkg and csc_cordic_cell.
//
//   channel   direction   handshake             fields
//   req       in          req_valid/req_stall   req_op, req_in_first/second/third
//   rsp       out         rsp_valid/rsp_stall   rsp_out_first/second/third, rsp_overflow
//
// One item is taken every cycle while req_stall is low.
// Input register, first row of CORDIC cells, m1 and m2, second row, f1 and f2, output register; one iteration per cell.
// Reset is synchronous and clears only the valid bits of the pipeline.
// While a result waits under rsp_stall the whole pipeline holds and req_stall is high.
`timescale 1ns / 1ps

module coordinate_system_converter_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [2:0]         req_op,
   input  logic signed [31:0] req_in_first,
   input  logic signed [31:0] req_in_second,
   input  logic signed [31:0] req_in_third,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_out_first,
   output logic signed [31:0] rsp_out_second,
   output logic signed [31:0] rsp_out_third,
   output logic               rsp_overflow
);
   import csc_pkg::*;

   typedef struct packed {
      side_type             sd;
      logic [HW-1:0]        hi;
      logic [HW-1:0]        lo;
      logic signed [PW-1:0] p_c;
      logic signed [PW-1:0] p_s;
      logic signed [31:0]   ang_b;
   } prod_type;

   typedef struct packed {
      side_type             sd;
      logic [MW-1:0]        mag_b;
      logic signed [QW-1:0] r1;
      logic signed [QW-1:0] r2;
      logic signed [31:0]   ang_b;
   } fin_type;

   logic               adv;

   logic               s0_valid_ff;
   logic [2:0]         s0_op_ff;
   logic signed [31:0] s0_a_ff;
   logic signed [31:0] s0_b_ff;
   logic signed [31:0] s0_c_ff;
   logic signed [ZW-1:0] s0_b_red;

   cell_type           a_link [CORDIC_STAGES+1];
   cell_type           b_link [CORDIC_STAGES+1];
   cell_type           a_head;
   cell_type           b_head;
   cell_type           ea;
   cell_type           eb;

   logic               m1_valid_ff;
   prod_type           m1_ff;
   prod_type           m1_in;
   logic               m2_valid_ff;
   side_type           m2_ff;
   side_type           m2_in;
   logic               f1_valid_ff;
   prod_type           f1_ff;
   prod_type           f1_in;
   logic               f2_valid_ff;
   fin_type            f2_ff;
   fin_type            f2_in;

   logic signed [CW-1:0] cs_a;
   logic signed [CW-1:0] sn_a;
   logic signed [CW-1:0] cs_b;
   logic signed [CW-1:0] sn_b;
   logic [DW-2:0]        xa;
   logic [DW-2:0]        xb;

   logic               rsp_valid_ff;
   logic signed [31:0] rsp_first_ff;
   logic signed [31:0] rsp_second_ff;
   logic signed [31:0] rsp_third_ff;
   logic               rsp_ovf_ff;
   logic signed [31:0] rsp_first_in;
   logic signed [31:0] rsp_second_in;
   logic signed [31:0] rsp_third_in;
   logic               rsp_ovf_in;

   sat_type            sat_ua;
   sat_type            sat_ub;
   sat_type            sat_mc;
   sat_type            sat_ms;
   sat_type            sat_r1;
   sat_type            sat_r2;

   // The whole pipeline moves unless a finished result is held back.
   assign adv       = ~(rsp_valid_ff & rsp_stall);
   assign req_stall = ~adv;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_op_ff <= req_op;
         s0_a_ff  <= req_in_first;
         s0_b_ff  <= req_in_second;
         s0_c_ff  <= req_in_third;
      end
   end

   // Azimuth brought into [-pi, pi].
   assign s0_b_red = reduce_angle(s0_b_ff);

   // Setup of the first row: magnitudes and atan2 or sine and cosine.
   always_comb begin
      a_head.sd       = '0;
      a_head.sd.valid = s0_valid_ff;
      a_head.sd.op    = s0_op_ff;
      a_head.sd.a     = s0_a_ff;
      a_head.sd.rb    = s0_b_red[31:0];
      a_head.sd.c     = s0_c_ff;
      case (s0_op_ff)
         OP_RECT_CYL, OP_RECT_SPH:
            a_head.cr = vec_init(guard_len(s0_a_ff), guard_len(s0_b_ff));
         OP_CYL_SPH:
            a_head.cr = vec_init(guard_len(s0_c_ff), guard_len(s0_a_ff));
         OP_CYL_RECT:
            a_head.cr = rot_init(s0_b_red);
         OP_SPH_CYL, OP_SPH_RECT:
            a_head.cr = rot_init(reduce_angle(s0_c_ff));
         default:
            a_head.cr = rot_init('0);
      endcase
   end

   assign a_link[0] = a_head;

   // First row of CORDIC cells.
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_row_a
      csc_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .stage_idx (IDX_W'(i)),
         .prev_cell (a_link[i]),
         .next_cell (a_link[i+1])
      );
   end

   assign ea = a_link[CORDIC_STAGES];

   // Gain compensation partial products and length times sine and cosine.
   always_comb begin
      xa   = mag_operand(ea.cr);
      cs_a = CW'(ea.cr.neg ? -ea.cr.x : ea.cr.x);
      sn_a = CW'(ea.cr.neg ? -ea.cr.y : ea.cr.y);
      m1_in.sd     = ea.sd;
      m1_in.sd.ang = ea.cr.zero ? '0 : clamp_angle(ea.cr.z);
      m1_in.hi     = HW'(xa >> 28) * HW'(INV_GAIN);
      m1_in.lo     = HW'(xa[27:0]) * HW'(INV_GAIN);
      m1_in.p_c    = PW'(ea.sd.a) * PW'(cs_a);
      m1_in.p_s    = PW'(ea.sd.a) * PW'(sn_a);
      m1_in.ang_b  = '0;
   end

   // Compensated magnitude and rounded products.
   always_comb begin
      m2_in     = m1_ff.sd;
      m2_in.mag = comp_sum(m1_ff.hi, m1_ff.lo);
      m2_in.mc  = RW'(round_q28(m1_ff.p_c));
      m2_in.ms  = RW'(round_q28(m1_ff.p_s));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
      end else if (adv) begin
         m1_valid_ff <= ea.sd.valid;
         m2_valid_ff <= m1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_ff <= m1_in;
         m2_ff <= m2_in;
      end
   end

   // Setup of the second row: polar angle of the sphere or the azimuth rotation.
   always_comb begin
      b_head.sd       = m2_ff;
      b_head.sd.valid = m2_valid_ff;
      case (m2_ff.op)
         OP_RECT_SPH:
            b_head.cr = vec_init(guard_len(m2_ff.c), $signed(DW'(m2_ff.mag)));
         OP_SPH_RECT:
            b_head.cr = rot_init(ZW'(m2_ff.rb));
         default:
            b_head.cr = rot_init('0);
      endcase
   end

   assign b_link[0] = b_head;

   // Second row of CORDIC cells.
   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_row_b
      csc_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .stage_idx (IDX_W'(i)),
         .prev_cell (b_link[i]),
         .next_cell (b_link[i+1])
      );
   end

   assign eb = b_link[CORDIC_STAGES];

   // Products after the second row.
   always_comb begin
      xb   = mag_operand(eb.cr);
      cs_b = CW'(eb.cr.neg ? -eb.cr.x : eb.cr.x);
      sn_b = CW'(eb.cr.neg ? -eb.cr.y : eb.cr.y);
      f1_in.sd    = eb.sd;
      f1_in.hi    = HW'(xb >> 28) * HW'(INV_GAIN);
      f1_in.lo    = HW'(xb[27:0]) * HW'(INV_GAIN);
      f1_in.p_c   = PW'(eb.sd.ms) * PW'(cs_b);
      f1_in.p_s   = PW'(eb.sd.ms) * PW'(sn_b);
      f1_in.ang_b = eb.cr.zero ? '0 : clamp_angle(eb.cr.z);
   end

   // Rounding after the second row.
   always_comb begin
      f2_in.sd    = f1_ff.sd;
      f2_in.mag_b = comp_sum(f1_ff.hi, f1_ff.lo);
      f2_in.r1    = round_q28(f1_ff.p_c);
      f2_in.r2    = round_q28(f1_ff.p_s);
      f2_in.ang_b = f1_ff.ang_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else if (adv) begin
         f1_valid_ff <= eb.sd.valid;
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_ff <= f1_in;
         f2_ff <= f2_in;
      end
   end

   // Result selection and saturation.
   always_comb begin
      sat_ua = sat32(unguard(f2_ff.sd.mag));
      sat_ub = sat32(unguard(f2_ff.mag_b));
      sat_mc = sat32(QW'(f2_ff.sd.mc));
      sat_ms = sat32(QW'(f2_ff.sd.ms));
      sat_r1 = sat32(f2_ff.r1);
      sat_r2 = sat32(f2_ff.r2);
      case (f2_ff.sd.op)
         OP_RECT_CYL: begin
            rsp_first_in  = sat_ua.val;
            rsp_second_in = f2_ff.sd.ang;
            rsp_third_in  = f2_ff.sd.c;
            rsp_ovf_in    = sat_ua.ovf;
         end
         OP_RECT_SPH: begin
            rsp_first_in  = sat_ub.val;
            rsp_second_in = f2_ff.sd.ang;
            rsp_third_in  = f2_ff.ang_b;
            rsp_ovf_in    = sat_ub.ovf;
         end
         OP_CYL_RECT: begin
            rsp_first_in  = sat_mc.val;
            rsp_second_in = sat_ms.val;
            rsp_third_in  = f2_ff.sd.c;
            rsp_ovf_in    = sat_mc.ovf | sat_ms.ovf;
         end
         OP_CYL_SPH: begin
            rsp_first_in  = sat_ua.val;
            rsp_second_in = f2_ff.sd.rb;
            rsp_third_in  = f2_ff.sd.ang;
            rsp_ovf_in    = sat_ua.ovf;
         end
         OP_SPH_CYL: begin
            rsp_first_in  = sat_ms.val;
            rsp_second_in = f2_ff.sd.rb;
            rsp_third_in  = sat_mc.val;
            rsp_ovf_in    = sat_ms.ovf | sat_mc.ovf;
         end
         OP_SPH_RECT: begin
            rsp_first_in  = sat_r1.val;
            rsp_second_in = sat_r2.val;
            rsp_third_in  = sat_mc.val;
            rsp_ovf_in    = sat_r1.ovf | sat_r2.ovf | sat_mc.ovf;
         end
         default: begin
            rsp_first_in  = '0;
            rsp_second_in = '0;
            rsp_third_in  = '0;
            rsp_ovf_in    = 1'b0;
         end
      endcase
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= f2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_first_ff  <= rsp_first_in;
         rsp_second_ff <= rsp_second_in;
         rsp_third_ff  <= rsp_third_in;
         rsp_ovf_ff    <= rsp_ovf_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_first  = rsp_first_ff;
   assign rsp_out_second = rsp_second_ff;
   assign rsp_out_third  = rsp_third_ff;
   assign rsp_overflow   = rsp_ovf_ff;

endmodule

FILE: rtl/csc_checker.sv
// Port-level checks for the coordinate system converter, bound to its top level.
// Depends only on the ports of coordinate_system_converter_core.
`timescale 1ns / 1ps

module csc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_out_first,
   input logic signed [31:0] rsp_out_second,
   input logic signed [31:0] rsp_out_third,
   input logic               rsp_overflow
);

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // The input side only stalls behind a held result.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a held result");

   // A held result item keeps its fields.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_out_first)
         && $stable(rsp_out_second) && $stable(rsp_out_third) && $stable(rsp_overflow)))
      else $error("held result item changed");

   // Overflow only comes with a field clamped at a range limit.
   a_ovf_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow) |->
         (rsp_out_first == 32'sh7FFF_FFFF || rsp_out_first == 32'sh8000_0000 ||
          rsp_out_second == 32'sh7FFF_FFFF || rsp_out_second == 32'sh8000_0000 ||
          rsp_out_third == 32'sh7FFF_FFFF || rsp_out_third == 32'sh8000_0000))
      else $error("overflow without a clamped field");

endmodule

bind coordinate_system_converter_core csc_checker u_csc_checker (.*);
